/* design/credit_request_multiplexer_macros.svh */
// assertion macros shared by the checker
`ifndef CREDIT_REQUEST_MULTIPLEXER_MACROS_SVH
`define CREDIT_REQUEST_MULTIPLEXER_MACROS_SVH

// checked only out of reset
`define CRM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset as well
`define CRM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/crm_pkg.sv */
package crm_pkg;

    localparam int MAX_CLIENTS    = 16;
    localparam int QUEUE_CAPACITY = 512;

    localparam int IDX_W  = 4;
    localparam int CNT_W  = 10;
    localparam int CFG_W  = 5;
    localparam int IN_W   = 40;
    localparam int OUT_W  = 16;

    localparam logic FUNC_REQUEST    = 1'b0;
    localparam logic FUNC_COMPLETION = 1'b1;

    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_ALREADY_FAILED = 3'd1,
        ST_BAD_CMD_LEN    = 3'd2,
        ST_BAD_CMPL_LEN   = 3'd3,
        ST_OVER_RESERVED  = 3'd4,
        ST_NO_ROOM        = 3'd5,
        ST_CMPL_OVERFLOW  = 3'd6,
        ST_BAD_INDEX      = 3'd7
    } status_t;

    typedef struct packed {
        logic load;
        logic exec;
    } dp_cmd_t;

endpackage

/* design/crm_datapath.sv */
module crm_datapath
    import crm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic [IN_W-1:0]   in_tdata,
    input  logic              in_tuser,
    output logic [OUT_W-1:0]  out_tdata
);

    localparam logic [CNT_W-1:0] CAP = CNT_W'(QUEUE_CAPACITY);

    logic [CFG_W-1:0] clients_in_use_reg;
    logic [CNT_W-1:0] reserved_reg [MAX_CLIENTS];
    logic             failed_reg   [MAX_CLIENTS];

    logic             func_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [CNT_W-1:0] pending_reg;
    logic [CNT_W-1:0] srv_used_reg;
    logic [CNT_W-1:0] cmpl_used_reg;
    logic [OUT_W-1:0] out_reg;

    logic             idx_ok;
    logic [CNT_W-1:0] res;
    logic             fl;
    logic [CNT_W-1:0] srv_free;
    logic [CNT_W-1:0] cmpl_free;
    logic [CNT_W-1:0] room;
    logic [CNT_W-1:0] min_a;
    logic [CNT_W-1:0] grant;

    logic [CNT_W-1:0] res_next;
    logic             fl_next;
    logic             state_we;
    logic [CNT_W-1:0] fwd;
    logic             deliver;
    logic             notify;
    status_t          status;

    assign idx_ok    = ({1'b0, idx_reg} < clients_in_use_reg)
                       && (32'(idx_reg) < MAX_CLIENTS);
    assign res       = reserved_reg[idx_reg];
    assign fl        = failed_reg[idx_reg];
    assign srv_free  = (srv_used_reg > CAP) ? '0 : CAP - srv_used_reg;
    assign cmpl_free = CAP - cmpl_used_reg;
    assign room      = cmpl_free - res;
    assign min_a     = (pending_reg < srv_free) ? pending_reg : srv_free;
    assign grant     = (min_a < room) ? min_a : room;

    always_comb
    begin
        res_next = res;
        fl_next  = fl;
        state_we = 1'b0;
        fwd      = '0;
        deliver  = 1'b0;
        notify   = 1'b0;
        status   = ST_OK;
        if (!idx_ok)
        begin
            status = ST_BAD_INDEX;
        end
        else if (func_reg == FUNC_REQUEST)
        begin
            state_we = 1'b1;
            if (fl)
            begin
                status = ST_ALREADY_FAILED;
            end
            else if (pending_reg > CAP)
            begin
                fl_next = 1'b1;
                status  = ST_BAD_CMD_LEN;
            end
            else if (cmpl_used_reg > CAP)
            begin
                fl_next = 1'b1;
                status  = ST_BAD_CMPL_LEN;
            end
            else if (res > cmpl_free)
            begin
                fl_next = 1'b1;
                status  = ST_OVER_RESERVED;
            end
            else if (res == cmpl_free)
            begin
                status = ST_NO_ROOM;
            end
            else
            begin
                fwd = grant;
                if (grant != '0)
                begin
                    res_next = res + grant;
                    notify   = 1'b1;
                end
            end
        end
        else
        begin
            state_we = 1'b1;
            if (res == '0)
            begin
                status = ST_BAD_INDEX;
            end
            else if (fl)
            begin
                res_next = res - CNT_W'(1);
                status   = ST_ALREADY_FAILED;
            end
            else if (cmpl_used_reg >= CAP)
            begin
                fl_next  = 1'b1;
                res_next = res - CNT_W'(1);
                status   = ST_CMPL_OVERFLOW;
            end
            else
            begin
                res_next = res - CNT_W'(1);
                deliver  = 1'b1;
                notify   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clients_in_use_reg <= CFG_W'(1);
            for (int i = 0; i < MAX_CLIENTS; i++)
            begin
                reserved_reg[i] <= '0;
                failed_reg[i]   <= 1'b0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                clients_in_use_reg <= cfg_wdata;
            end
            if (cmd.exec && state_we)
            begin
                reserved_reg[idx_reg] <= res_next;
                failed_reg[idx_reg]   <= fl_next;
            end
        end
    end

    // input and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg      <= in_tuser;
            idx_reg       <= in_tdata[3:0];
            pending_reg   <= in_tdata[13:4];
            srv_used_reg  <= in_tdata[23:14];
            cmpl_used_reg <= in_tdata[33:24];
        end
        if (cmd.exec)
        begin
            out_reg <= {idx_ok & fl_next, status, notify, deliver, fwd};
        end
    end

    assign out_tdata = out_reg;

endmodule

/* design/crm_ctrl.sv */
module crm_ctrl
    import crm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // wait for the result register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* design/credit_request_multiplexer.sv */
// channel   dir  width  contents
// s_axis    in   40+1   tdata: client_index, cmd_pending, server_cmd_used,
//                       cmpl_slots_used; tuser: func
// m_axis    out  16     tdata: forward_count, deliver, notify, status, is_failed
// cfg       in   5      clients_in_use, written when cfg_we is high
//
// each beat is first captured, then goes through one read-modify-write of the
// client's reservation counter and failed flag
// a result is held in an output register, so the next beat is accepted
// while it waits; a stalled result holds back only the following update
// rst_n clears all reservations and failed flags, clients_in_use resets to 1
module credit_request_multiplexer
    import crm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // client_index, cmd_pending, server_cmd_used, cmpl_slots_used, zero fill
    input  logic [IN_W-1:0]   s_axis_tdata,
    // func
    input  logic              s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // forward_count, deliver, notify, status, is_failed
    output logic [OUT_W-1:0]  m_axis_tdata,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    dp_cmd_t cmd;

    crm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    crm_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_tdata  (s_axis_tdata),
        .in_tuser  (s_axis_tuser),
        .out_tdata (m_axis_tdata)
    );

endmodule

/* design/crm_checker.sv */
`include "credit_request_multiplexer_macros.svh"

module crm_checker
    import crm_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [OUT_W-1:0]  m_axis_tdata
);

    `CRM_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result dropped or changed while stalled")
    `CRM_ASSERT(a_one_in_flight, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "beat accepted while one is in progress")
    `CRM_ASSERT(a_bad_idx_quiet, m_axis_tvalid && m_axis_tdata[14:12] == ST_BAD_INDEX |-> m_axis_tdata[11:0] == '0, "bad index result carries a grant or notify")
    `CRM_ASSERT(a_deliver_ok, m_axis_tvalid && m_axis_tdata[10] |-> m_axis_tdata[11] && m_axis_tdata[14:12] == ST_OK && m_axis_tdata[9:0] == '0, "delivery without notify or with grant")
    `CRM_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !m_axis_tvalid, "result valid during reset")

endmodule

bind credit_request_multiplexer crm_checker u_chk (.*);
